/* design/pfd_pkg.sv */
// Shared constants for the filtered-derivative PID controller.
`default_nettype none
package pfd_pkg;

	localparam int PFD_DATA_WIDTH = 32;
	localparam int PFD_GAIN_WIDTH = 24;
	localparam int FRAC_BITS      = 16;
	localparam int FGAIN_WIDTH    = 16;
	localparam int REG_IDX_W      = 3;

	// Q0.16 constants: 0.1 and 0.586 (2 - 1.414)
	localparam int TENTH_Q16    = 6554;
	localparam int FEEDBACK_Q16 = 38403;

	localparam logic [1:0] WARMUP_DONE = 2'd3;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_SETPOINT     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FILTER_GAIN  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_WINDUP_LIMIT = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_DRIVE_LOW    = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_DRIVE_HIGH   = 3'd7;

	// Register reset values
	localparam int SETPOINT_RST   = 0;
	localparam int PROP_GAIN_RST  = 74345;
	localparam int INTEG_GAIN_RST = 86734;
	localparam int DERIV_GAIN_RST = 160779;
	localparam int FILTER_RST     = 0;
	localparam int WINDUP_RST     = 3276800;
	localparam int DRIVE_LOW_RST  = -327680000;
	localparam int DRIVE_HIGH_RST = 327680000;

endpackage
`default_nettype wire

/* design/pfd_mul.sv */
// Shared multiplier: registered product, round half up by 2^16, saturate.
`default_nettype none
module pfd_mul #(
	parameter int DATA_WIDTH = pfd_pkg::PFD_DATA_WIDTH,
	parameter int GAIN_WIDTH = pfd_pkg::PFD_GAIN_WIDTH
) (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic signed [DATA_WIDTH-1:0] a,
	input  wire logic signed [GAIN_WIDTH:0]   b,
	output logic signed [DATA_WIDTH-1:0]      q
);
	import pfd_pkg::*;

	localparam int PW = DATA_WIDTH + GAIN_WIDTH + 1;
	localparam logic signed [PW-1:0] SAT_MAX =
		{{(PW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [PW-1:0] SAT_MIN = ~SAT_MAX;
	localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

	logic signed [PW-1:0] prod_q;
	logic signed [PW-1:0] rnd;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PW'(a) * PW'(b);
		end
	end

	// Arithmetic shift of the biased product is the floor
	assign rnd = (prod_q + HALF) >>> FRAC_BITS;

	always_comb begin
		if (rnd > SAT_MAX) begin
			q = SAT_MAX[DATA_WIDTH-1:0];
		end else if (rnd < SAT_MIN) begin
			q = SAT_MIN[DATA_WIDTH-1:0];
		end else begin
			q = rnd[DATA_WIDTH-1:0];
		end
	end

endmodule
`default_nettype wire

/* design/pid_filtered_derivative.sv */
// PID controller with anti-windup and filtered derivative, top level.
// One measurement transfer yields one drive result. After a transfer the block
// is busy while a small sequencer runs the six products of a tick
// (integral step, filter feedback, filter gain, and the three PID terms)
// through one shared multiplier, one product per cycle, with one step between
// the filter feedback and filter gain products to form the filter branch sum
// and a last step to sum and clamp the drive. That last step loads the result
// into the output register, and the next measurement can be taken once the
// sequencer is back in idle. A result left waiting in the output register
// holds the sequencer in its last step.
// Configuration writes take effect at once and belong in idle periods.
`default_nettype none
module pid_filtered_derivative #(
	parameter int DATA_WIDTH = pfd_pkg::PFD_DATA_WIDTH,
	parameter int GAIN_WIDTH = pfd_pkg::PFD_GAIN_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [pfd_pkg::REG_IDX_W-1:0]   cfg_index,
	input  wire logic [DATA_WIDTH-1:0]           cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [DATA_WIDTH-1:0]    measurement,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic signed [DATA_WIDTH-1:0]         drive,
	output logic                                 saturated
);
	import pfd_pkg::*;

	localparam int WW = DATA_WIDTH + 6;
	localparam logic signed [WW-1:0] SAT_MAX =
		{{(WW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [WW-1:0] SAT_MIN = ~SAT_MAX;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_DERIV   = 4'd1;
	localparam logic [3:0] ST_INTEG   = 4'd2;
	localparam logic [3:0] ST_BRANCH  = 4'd3;
	localparam logic [3:0] ST_FILT    = 4'd4;
	localparam logic [3:0] ST_PROP    = 4'd5;
	localparam logic [3:0] ST_ITERM   = 4'd6;
	localparam logic [3:0] ST_DTERM   = 4'd7;
	localparam logic [3:0] ST_DRIVE   = 4'd8;

	function automatic logic signed [DATA_WIDTH-1:0] sat_d(input logic signed [WW-1:0] x);
		if (x > SAT_MAX) begin
			sat_d = SAT_MAX[DATA_WIDTH-1:0];
		end else if (x < SAT_MIN) begin
			sat_d = SAT_MIN[DATA_WIDTH-1:0];
		end else begin
			sat_d = x[DATA_WIDTH-1:0];
		end
	endfunction

	// Configuration registers
	logic signed [DATA_WIDTH-1:0]  setpoint_q;
	logic signed [GAIN_WIDTH-1:0]  kp_q;
	logic signed [GAIN_WIDTH-1:0]  ki_q;
	logic signed [GAIN_WIDTH-1:0]  kd_q;
	logic        [FGAIN_WIDTH-1:0] fgain_q;
	logic        [DATA_WIDTH-2:0]  windup_q;
	logic signed [DATA_WIDTH-1:0]  drive_low_q;
	logic signed [DATA_WIDTH-1:0]  drive_high_q;

	// Controller state
	logic [3:0]                   state_q;
	logic signed [DATA_WIDTH-1:0] prev_err_q;
	logic signed [DATA_WIDTH-1:0] dh0_q;
	logic signed [DATA_WIDTH-1:0] dh1_q;
	logic signed [DATA_WIDTH-1:0] fh0_q;
	logic signed [DATA_WIDTH-1:0] fh1_q;
	logic signed [DATA_WIDTH-1:0] integ_q;
	logic [1:0]                   warm_q;
	logic                         out_valid_q;

	// Working registers
	logic signed [DATA_WIDTH-1:0] err_q;
	logic signed [DATA_WIDTH-1:0] d0_q;
	logic signed [DATA_WIDTH-1:0] br_q;
	logic signed [DATA_WIDTH-1:0] fd_q;
	logic signed [DATA_WIDTH+1:0] acc_q;
	logic signed [DATA_WIDTH-1:0] drive_q;
	logic                         sat_q;

	logic                         in_xfer;
	logic                         out_free;
	logic                         mul_en;
	logic signed [DATA_WIDTH-1:0] mul_a;
	logic signed [GAIN_WIDTH:0]   mul_b;
	logic signed [DATA_WIDTH-1:0] mul_r;

	logic signed [DATA_WIDTH-1:0] err_n;
	logic signed [WW-1:0]         diff;
	logic signed [DATA_WIDTH-1:0] d0_n;
	logic signed [DATA_WIDTH-1:0] isum;
	logic signed [DATA_WIDTH-1:0] ilim;
	logic signed [DATA_WIDTH-1:0] integ_n;
	logic signed [DATA_WIDTH-1:0] br_n;
	logic signed [DATA_WIDTH-1:0] fd_n;
	logic signed [DATA_WIDTH-1:0] u_sum;
	logic signed [DATA_WIDTH-1:0] u_n;
	logic                         usat_n;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign saturated = sat_q;

	// Operand select for the shared multiplier
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (state_q)
			ST_DERIV: begin
				mul_a = err_q;
				mul_b = (GAIN_WIDTH+1)'(TENTH_Q16);
			end
			ST_INTEG: begin
				mul_a = fh1_q;
				mul_b = (GAIN_WIDTH+1)'(FEEDBACK_Q16);
			end
			ST_FILT: begin
				mul_a = br_q;
				mul_b = $signed((GAIN_WIDTH+1)'({1'b0, fgain_q}));
			end
			ST_PROP: begin
				mul_a = err_q;
				mul_b = (GAIN_WIDTH+1)'(kp_q);
			end
			ST_ITERM: begin
				mul_a = integ_q;
				mul_b = (GAIN_WIDTH+1)'(ki_q);
			end
			ST_DTERM: begin
				mul_a = fd_q;
				mul_b = (GAIN_WIDTH+1)'(kd_q);
			end
			default: begin
				// hold the last product in idle, in the branch step and while the result waits
				mul_en = 1'b0;
			end
		endcase
	end

	pfd_mul #(
		.DATA_WIDTH(DATA_WIDTH),
		.GAIN_WIDTH(GAIN_WIDTH)
	) u_pfd_mul (
		.clk(clk),
		.en (mul_en),
		.a  (mul_a),
		.b  (mul_b),
		.q  (mul_r)
	);

	// Datapath around the multiplier
	always_comb begin
		err_n = sat_d(WW'(setpoint_q) - WW'(measurement));

		diff = WW'(err_q) - WW'(prev_err_q);
		d0_n = sat_d((diff <<< 3) + (diff <<< 1));

		isum = sat_d(WW'(integ_q) + WW'(mul_r));
		ilim = $signed({1'b0, windup_q});
		if (isum > ilim) begin
			integ_n = ilim;
		end else if (isum < -ilim) begin
			integ_n = -ilim;
		end else begin
			integ_n = isum;
		end

		br_n = sat_d(WW'(dh1_q) + (WW'(dh0_q) <<< 1) + WW'(d0_q) - WW'(mul_r));

		fd_n = (warm_q == WARMUP_DONE) ? mul_r : '0;

		// high clamp first, low clamp wins when the limits cross
		u_sum  = sat_d(WW'(acc_q) + WW'(mul_r));
		u_n    = u_sum;
		usat_n = 1'b0;
		if (u_n > drive_high_q) begin
			u_n    = drive_high_q;
			usat_n = 1'b1;
		end
		if (u_n < drive_low_q) begin
			u_n    = drive_low_q;
			usat_n = 1'b1;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q   <= DATA_WIDTH'(SETPOINT_RST);
			kp_q         <= GAIN_WIDTH'(PROP_GAIN_RST);
			ki_q         <= GAIN_WIDTH'(INTEG_GAIN_RST);
			kd_q         <= GAIN_WIDTH'(DERIV_GAIN_RST);
			fgain_q      <= FGAIN_WIDTH'(FILTER_RST);
			windup_q     <= (DATA_WIDTH-1)'(WINDUP_RST);
			drive_low_q  <= DATA_WIDTH'(DRIVE_LOW_RST);
			drive_high_q <= DATA_WIDTH'(DRIVE_HIGH_RST);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SETPOINT:     setpoint_q   <= cfg_data;
				REG_PROP_GAIN:    kp_q         <= cfg_data[GAIN_WIDTH-1:0];
				REG_INTEG_GAIN:   ki_q         <= cfg_data[GAIN_WIDTH-1:0];
				REG_DERIV_GAIN:   kd_q         <= cfg_data[GAIN_WIDTH-1:0];
				REG_FILTER_GAIN:  fgain_q      <= cfg_data[FGAIN_WIDTH-1:0];
				REG_WINDUP_LIMIT: windup_q     <= cfg_data[DATA_WIDTH-2:0];
				REG_DRIVE_LOW:    drive_low_q  <= cfg_data;
				REG_DRIVE_HIGH:   drive_high_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_err_q  <= '0;
			dh0_q       <= '0;
			dh1_q       <= '0;
			fh0_q       <= '0;
			fh1_q       <= '0;
			integ_q     <= '0;
			warm_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result, else drop the one just taken
			if (state_q == ST_DRIVE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_DERIV;
					end
				end
				ST_DERIV:  state_q <= ST_INTEG;
				ST_INTEG: begin
					integ_q <= integ_n;
					state_q <= ST_BRANCH;
				end
				ST_BRANCH: state_q <= ST_FILT;
				ST_FILT:   state_q <= ST_PROP;
				ST_PROP: begin
					dh1_q      <= dh0_q;
					dh0_q      <= d0_q;
					fh1_q      <= fh0_q;
					fh0_q      <= fd_n;
					prev_err_q <= err_q;
					if (warm_q != WARMUP_DONE) begin
						warm_q <= warm_q + 2'd1;
					end
					state_q <= ST_ITERM;
				end
				ST_ITERM:  state_q <= ST_DTERM;
				ST_DTERM:  state_q <= ST_DRIVE;
				ST_DRIVE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working values, no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			err_q <= err_n;
		end
		case (state_q)
			ST_DERIV:  d0_q  <= d0_n;
			ST_BRANCH: br_q  <= br_n;
			ST_PROP:   fd_q  <= fd_n;
			ST_ITERM:  acc_q <= (DATA_WIDTH+2)'(mul_r);
			ST_DTERM:  acc_q <= acc_q + (DATA_WIDTH+2)'(mul_r);
			ST_DRIVE: begin
				if (out_free) begin
					drive_q <= u_n;
					sat_q   <= usat_n;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

/* design/pfd_checker.sv */
// Port-level checks for the PID controller, bound to the top level.
`default_nettype none
module pfd_checker #(
	parameter int DATA_WIDTH = pfd_pkg::PFD_DATA_WIDTH
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [DATA_WIDTH-1:0] drive,
	input wire logic                  saturated
);

	// A result waiting on the output holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(saturated))
		else $error("output changed while stalled");

	// A transfer makes the block busy for the sequencer run
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("input accepted during a tick in progress");

	// A new result only appears from a tick in progress
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a tick in progress");

endmodule

bind pid_filtered_derivative pfd_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_pfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.drive    (drive),
	.saturated(saturated)
);
`default_nettype wire

/* tb/sv/pid_filtered_derivative_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the filtered-derivative PID controller.
module pid_filtered_derivative_test;
	import pfd_pkg::*;

	localparam int DW          = PFD_DATA_WIDTH;
	localparam int GW          = PFD_GAIN_WIDTH;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 118;

	typedef struct packed {
		logic signed [DW-1:0] drive;
		logic                 saturated;
	} drive_res_t;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [REG_IDX_W-1:0]   idx;
		logic [DW-1:0]          value;
		logic                   typed;
		drive_res_t             want;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [DW-1:0]        cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic signed [DW-1:0] measurement;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [DW-1:0] drive;
	logic                 saturated;

	// controller copy: configuration
	longint sp, kp, ki, kd, fgain, wlim, lo_lim, hi_lim;
	// controller copy: tick state
	longint     prev_err, integ, plant;
	longint     d_hist[2];
	longint     f_hist[2];
	logic [1:0] warm;

	drive_res_t pending_drives[$];
	drive_res_t seen;
	stim_row_t  dir_rows[$];
	int         errors = 0;
	int         cycle_count = 0;
	int         rx_hold = 0;
	logic       tx_gaps = 1'b1;
	logic       rx_stalls = 1'b1;

	pid_filtered_derivative i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.measurement (measurement),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.drive       (drive),
		.saturated   (saturated)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic longint sat_q(longint x);
		longint hi;
		hi = (64'sd1 <<< (DW - 1)) - 1;
		if (x > hi) return hi;
		if (x < -hi - 1) return -hi - 1;
		return x;
	endfunction

	// Q.16 product, round half up, then saturate
	function automatic longint mul_q16(longint a, longint b);
		longint p;
		p = a * b;
		return sat_q((p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
	endfunction

	task automatic compute_drive(input logic signed [DW-1:0] meas, output drive_res_t res);
		longint err, d0, fd, br, u;
		logic   clamped;
		err = sat_q(sp - longint'(meas));
		d0 = sat_q((err - prev_err) * 10);
		integ = sat_q(integ + mul_q16(err, TENTH_Q16));
		if (integ > wlim) integ = wlim;
		if (integ < -wlim) integ = -wlim;
		if (warm < WARMUP_DONE) begin
			fd = 0;
			warm = warm + 2'd1;
		end else begin
			br = sat_q(d_hist[1] + 2 * d_hist[0] + d0 - mul_q16(f_hist[1], FEEDBACK_Q16));
			fd = mul_q16(br, fgain);
		end
		d_hist[1] = d_hist[0];
		d_hist[0] = d0;
		f_hist[1] = f_hist[0];
		f_hist[0] = fd;
		prev_err = err;
		u = sat_q(mul_q16(kp, err) + mul_q16(ki, integ) + mul_q16(kd, fd));
		clamped = 1'b0;
		// high clamp first, so crossed limits end on the low one
		if (u > hi_lim) begin
			u = hi_lim;
			clamped = 1'b1;
		end
		if (u < lo_lim) begin
			u = lo_lim;
			clamped = 1'b1;
		end
		res.drive = u[DW-1:0];
		res.saturated = clamped;
	endtask

	function automatic int idle_len();
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void plan_row(row_kind_t k, logic [REG_IDX_W-1:0] i, logic [DW-1:0] v,
			logic t, logic [DW-1:0] d, logic s);
		stim_row_t r;
		r.kind = k;
		r.idx = i;
		r.value = v;
		r.typed = t;
		r.want.drive = d;
		r.want.saturated = s;
		dir_rows.push_back(r);
	endfunction

	function automatic logic [DW-1:0] cfg_pick(logic [REG_IDX_W-1:0] idx, logic extreme);
		logic hi_end;
		int   pick;
		hi_end = $urandom_range(0, 1);
		pick = $urandom_range(0, 9);
		case (idx)
			REG_SETPOINT: begin
				if (extreme) return hi_end ? 32'h7FFF_FFFF : 32'h8000_0000;
				if (pick < 7) return 32'(int'($urandom_range(0, 100 << 16)) - (50 << 16));
				return $urandom;
			end
			REG_PROP_GAIN, REG_INTEG_GAIN, REG_DERIV_GAIN: begin
				if (extreme) return hi_end ? 32'h007F_FFFF : 32'hFF80_0000;
				if (pick < 7) return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
				return $urandom;
			end
			REG_FILTER_GAIN: begin
				if (extreme) return hi_end ? 32'h0000_FFFF : 32'h0;
				if (pick < 6) return $urandom_range(0, 6000);
				return $urandom;
			end
			REG_WINDUP_LIMIT: begin
				if (extreme) return hi_end ? 32'h7FFF_FFFF : 32'h0;
				if (pick < 7) return $urandom_range(0, 200 << 16);
				return $urandom;
			end
			REG_DRIVE_LOW: begin
				if (extreme) return hi_end ? 32'h7FFF_FFFF : 32'h8000_0000;
				if (pick < 8) return 32'(-int'($urandom_range(1 << 16, 1000 << 16)));
				return $urandom;
			end
			REG_DRIVE_HIGH: begin
				if (extreme) return hi_end ? 32'h7FFF_FFFF : 32'h8000_0000;
				if (pick < 8) return $urandom_range(1 << 16, 1000 << 16);
				return $urandom;
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic program_reg(input logic [REG_IDX_W-1:0] idx, input logic [DW-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SETPOINT:     sp = longint'($signed(value));
			REG_PROP_GAIN:    kp = longint'($signed(value[GW-1:0]));
			REG_INTEG_GAIN:   ki = longint'($signed(value[GW-1:0]));
			REG_DERIV_GAIN:   kd = longint'($signed(value[GW-1:0]));
			REG_FILTER_GAIN:  fgain = longint'(value[FGAIN_WIDTH-1:0]);
			REG_WINDUP_LIMIT: wlim = longint'(value[DW-2:0]);
			REG_DRIVE_LOW:    lo_lim = longint'($signed(value));
			REG_DRIVE_HIGH:   hi_lim = longint'($signed(value));
			default: ;
		endcase
	endtask

	// drop valid and hold until every drive has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_drives.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic offer(input logic [DW-1:0] m, input logic typed, input drive_res_t want);
		drive_res_t res;
		int         gap;
		gap = (tx_gaps && $urandom_range(0, 2) == 0) ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		measurement <= m;
		do @(posedge clk); while (!in_ready);
		compute_drive(m, res);
		pending_drives.push_back(typed ? want : res);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
			rx_hold = idle_len() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_drives.size() == 0) begin
				$display("%0t: drive transfer with nothing pending, got drive %0d saturated %0b",
					$time, drive, saturated);
				errors++;
			end else begin
				seen = pending_drives.pop_front();
				if (drive !== seen.drive) begin
					$display("%0t: drive mismatch, expected %0d, got %0d",
						$time, seen.drive, drive);
					errors++;
				end
				if (saturated !== seen.saturated) begin
					$display("%0t: saturated mismatch, expected %0b, got %0b",
						$time, seen.saturated, saturated);
					errors++;
				end
			end
		end
	end

	initial begin
		stim_row_t     row;
		logic [DW-1:0] m;
		longint        step;
		int            span, pick;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		measurement = '0;

		sp = SETPOINT_RST;
		kp = PROP_GAIN_RST;
		ki = INTEG_GAIN_RST;
		kd = DERIV_GAIN_RST;
		fgain = FILTER_RST;
		wlim = WINDUP_RST;
		lo_lim = DRIVE_LOW_RST;
		hi_lim = DRIVE_HIGH_RST;
		prev_err = 0;
		integ = 0;
		plant = 0;
		d_hist[0] = 0;
		d_hist[1] = 0;
		f_hist[0] = 0;
		f_hist[1] = 0;
		warm = '0;

		// reset defaults: zero error, then full-scale errors both ways during warmup
		plan_row(ROW_ITEM, REG_SETPOINT, 32'h0000_0000, 1'b1, 32'h0, 1'b0);
		plan_row(ROW_ITEM, REG_SETPOINT, 32'h8000_0000, 1'b1, 32'(DRIVE_HIGH_RST), 1'b1);
		plan_row(ROW_ITEM, REG_SETPOINT, 32'h7FFF_FFFF, 1'b1, 32'(DRIVE_LOW_RST), 1'b1);
		plan_row(ROW_ITEM, REG_SETPOINT, 32'h0000_0000, 1'b0, 32'h0, 1'b0);
		// full filter gain, top derivative gain and widest integral bound
		plan_row(ROW_WRITE, REG_FILTER_GAIN, 32'h0000_FFFF, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_WRITE, REG_DERIV_GAIN, 32'h007F_FFFF, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_WRITE, REG_WINDUP_LIMIT, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_ITEM, REG_SETPOINT, 32'h0001_0000, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_ITEM, REG_SETPOINT, 32'hFFFF_0000, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_ITEM, REG_SETPOINT, 32'h1234_5678, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_ITEM, REG_SETPOINT, 32'h0000_0000, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_ITEM, REG_SETPOINT, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_ITEM, REG_SETPOINT, 32'h0000_0001, 1'b0, 32'h0, 1'b0);
		// most negative setpoint and gains
		plan_row(ROW_WRITE, REG_SETPOINT, 32'h8000_0000, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_WRITE, REG_PROP_GAIN, 32'hFF80_0000, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_WRITE, REG_INTEG_GAIN, 32'hFF80_0000, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_WRITE, REG_DERIV_GAIN, 32'hFF80_0000, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_ITEM, REG_SETPOINT, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_ITEM, REG_SETPOINT, 32'h8000_0000, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_ITEM, REG_SETPOINT, 32'h0000_0000, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_ITEM, REG_SETPOINT, 32'h0000_8000, 1'b0, 32'h0, 1'b0);
		// crossed limits: the low limit always wins
		plan_row(ROW_WRITE, REG_DRIVE_LOW, 32'd100, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_WRITE, REG_DRIVE_HIGH, 32'hFFFF_FF9C, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_ITEM, REG_SETPOINT, 32'h0000_0000, 1'b1, 32'd100, 1'b1);
		plan_row(ROW_ITEM, REG_SETPOINT, 32'h7FFF_FFFF, 1'b1, 32'd100, 1'b1);
		plan_row(ROW_ITEM, REG_SETPOINT, 32'h8000_0000, 1'b1, 32'd100, 1'b1);
		// widest limits, no integral, no filter, top setpoint
		plan_row(ROW_WRITE, REG_DRIVE_LOW, 32'h8000_0000, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_WRITE, REG_DRIVE_HIGH, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_WRITE, REG_WINDUP_LIMIT, 32'h0000_0000, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_WRITE, REG_FILTER_GAIN, 32'h0000_0000, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_WRITE, REG_SETPOINT, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_ITEM, REG_SETPOINT, 32'h8000_0000, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_ITEM, REG_SETPOINT, 32'h0000_0000, 1'b0, 32'h0, 1'b0);
		plan_row(ROW_ITEM, REG_SETPOINT, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			row = dir_rows[r];
			if (row.kind == ROW_WRITE) begin
				settle();
				program_reg(row.idx, row.value);
			end else begin
				offer(row.value, row.typed, row.want);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			for (int i = 0; i < 8; i++)
				program_reg(i[REG_IDX_W-1:0], cfg_pick(i[REG_IDX_W-1:0], phase == PHASES - 1));
			plant = sp;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0) begin
					tx_gaps = $urandom_range(0, 3) != 0;
					rx_stalls = $urandom_range(0, 3) != 0;
				end
				if ($urandom_range(0, 49) == 0)
					settle();
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					// plant drifting toward the setpoint with random steps
					span = 1 << $urandom_range(4, 20);
					step = longint'($urandom_range(0, 2 * span)) - span;
					plant = sat_q(plant + step + (sp - plant) / 8);
					m = plant[DW-1:0];
				end else if (pick < 92) begin
					m = $urandom;
				end else begin
					m = pick[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
				end
				offer(m, 1'b0, '0);
			end
		end

		settle();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
